>>> hw/rtl/multi_pattern_match_scorer_defines.svh
// assertion macros for the pattern match scorer
`ifndef MULTI_PATTERN_MATCH_SCORER_DEFINES_SVH
`define MULTI_PATTERN_MATCH_SCORER_DEFINES_SVH
// property that must hold after reset settles
`define MPMS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// property that is checked during reset too
`define MPMS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

>>> hw/rtl/mpms_pkg.sv
// package: constants, types and codes of the pattern match scorer
package mpms_pkg;
   localparam int MaxNodes  = 256;
   localparam int NodeBits  = $clog2(MaxNodes);
   localparam int CntBits   = $clog2(MaxNodes + 1);
   localparam int ScoreBits = 16;
   localparam int GotoDepth = MaxNodes * 256;
   localparam int GotoBits  = NodeBits + 8;

   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_BUILD  = 2'd1;
   localparam logic [1:0] ACT_SCAN   = 2'd2;
   localparam logic [1:0] ACT_NONE   = 2'd3;

   localparam logic [1:0] REG_SCORE_PER_MATCH = 2'd0;
   localparam logic [1:0] REG_LOW_LIMIT       = 2'd1;
   localparam logic [1:0] REG_MEDIUM_LIMIT    = 2'd2;
   localparam logic [1:0] REG_HIGH_LIMIT      = 2'd3;

   localparam logic [1:0] RISK_LOW      = 2'd0;
   localparam logic [1:0] RISK_MEDIUM   = 2'd1;
   localparam logic [1:0] RISK_HIGH     = 2'd2;
   localparam logic [1:0] RISK_CRITICAL = 2'd3;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] byte_value;
      logic       last;
   } req_type;

   typedef struct packed {
      logic                 status;
      logic [7:0]           position_matches;
      logic [ScoreBits-1:0] score;
      logic [1:0]           risk_class;
      logic                 query_done;
   } rsp_type;
endpackage

>>> hw/rtl/mpms_req_if.sv
// valid/ready channel carrying one request beat
interface mpms_req_if;
   import mpms_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> hw/rtl/mpms_rsp_if.sv
// valid/ready channel carrying one result beat
interface mpms_rsp_if;
   import mpms_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> hw/rtl/mpms_ram.sv
// generic single-port-write, one-read ram with registered read data
module mpms_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

>>> hw/rtl/multi_pattern_match_scorer.sv
// top level: aho-corasick byte matcher with scoring and risk class
//  channel | dir | signals                          | payload
//  req     | in  | req_if.valid/ready               | action, byte_value, last
//  rsp     | out | rsp_if.valid/ready               | status, position_matches, score, ...
//  csr     | in  | csr_wr_en, csr_index, csr_wdata  | register write
// after reset a clearing pass zeroes all 65536 goto table entries; no beat is taken then.
// insert follows or adds one trie edge per byte and bumps the end counts on a last byte;
// scan follows failure links before it scores, and an unused action 3 is answered from idle;
// build tries every byte of the root and each queued node, resolving deeper children's links.
// a finished result sits in the output register until taken; the next beat waits for it.
`include "multi_pattern_match_scorer_defines.svh"
module multi_pattern_match_scorer (
   input  logic             clock,
   input  logic             reset,
   mpms_req_if.sink         req_if,
   mpms_rsp_if.source       rsp_if,
   input  logic             csr_wr_en,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_wdata
);
   import mpms_pkg::*;

   typedef enum logic [16:0] {
      ST_CLEAR   = 17'h00001,
      ST_IDLE    = 17'h00002,
      ST_INS_RD  = 17'h00004,
      ST_INS_CHK = 17'h00008,
      ST_INS_END = 17'h00010,
      ST_SC_RD   = 17'h00020,
      ST_SC_CHK  = 17'h00040,
      ST_SC_FL   = 17'h00080,
      ST_SC_CNT  = 17'h00100,
      ST_SC_MUL  = 17'h00200,
      ST_BL_RD   = 17'h00400,
      ST_BL_CHK  = 17'h00800,
      ST_BL_Q    = 17'h01000,
      ST_BL_FRD  = 17'h02000,
      ST_BL_FCHK = 17'h04000,
      ST_BL_CNT  = 17'h08000,
      ST_OUT     = 17'h10000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [7:0]  spm_ff;
   logic [15:0] low_ff, med_ff, high_ff;

   // control state
   logic [CntBits-1:0]   total_ff, total_in;
   logic [NodeBits-1:0]  cursor_ff, cursor_in;
   logic [NodeBits-1:0]  scan_ff, scan_in;
   logic [ScoreBits-1:0] run_ff, run_in;
   logic                 built_ff, built_in;
   logic                 dropped_ff, dropped_in;
   logic [GotoBits-1:0]  clr_ff, clr_in;

   // working registers
   req_type              req_ff, req_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [NodeBits-1:0]  node_ff, node_in;   // current / parent node
   logic [8:0]           b_ff, b_in;         // build byte counter
   logic [NodeBits-1:0]  f_ff, f_in;
   logic [NodeBits-1:0]  child_ff, child_in;
   logic [CntBits-1:0]   head_ff, head_in, tail_ff, tail_in;
   logic [CntBits-1:0]   guard_ff, guard_in;
   logic                 root_phase_ff, root_phase_in;
   logic [7:0]           matches_ff, matches_in;
   logic [15:0]          prod_ff, prod_in;

   // memories
   logic                goto_we;
   logic [GotoBits-1:0] goto_wa, goto_ra;
   logic [NodeBits-1:0] goto_wd, goto_rd;
   logic                fail_we;
   logic [NodeBits-1:0] fail_wa, fail_wd, fail_ra, fail_rd;
   logic                own_we;
   logic [NodeBits-1:0] own_wa, own_ra;
   logic [7:0]          own_wd, own_rd;
   logic                suf_we;
   logic [NodeBits-1:0] suf_wa, suf_ra;
   logic [7:0]          suf_wd, suf_rd;
   logic                q_we;
   logic [NodeBits-1:0] q_wa, q_wd, q_ra, q_rd;

   mpms_ram #(.Width(NodeBits), .Depth(GotoDepth)) u_goto (
      .clock, .wr_en(goto_we), .wr_addr(goto_wa), .wr_data(goto_wd),
      .rd_addr(goto_ra), .rd_data(goto_rd));
   mpms_ram #(.Width(NodeBits), .Depth(MaxNodes)) u_fail (
      .clock, .wr_en(fail_we), .wr_addr(fail_wa), .wr_data(fail_wd),
      .rd_addr(fail_ra), .rd_data(fail_rd));
   mpms_ram #(.Width(8), .Depth(MaxNodes)) u_own (
      .clock, .wr_en(own_we), .wr_addr(own_wa), .wr_data(own_wd),
      .rd_addr(own_ra), .rd_data(own_rd));
   mpms_ram #(.Width(8), .Depth(MaxNodes)) u_suf (
      .clock, .wr_en(suf_we), .wr_addr(suf_wa), .wr_data(suf_wd),
      .rd_addr(suf_ra), .rd_data(suf_rd));
   mpms_ram #(.Width(NodeBits), .Depth(MaxNodes)) u_queue (
      .clock, .wr_en(q_we), .wr_addr(q_wa), .wr_data(q_wd),
      .rd_addr(q_ra), .rd_data(q_rd));

   // own/suffix counts are only meaningful for nodes created since reset: track with valid bits
   logic [MaxNodes-1:0] cnt_valid_ff, cnt_valid_in;
   logic                own_rd_ok, suf_rd_ok;
   logic [7:0]          own_v, suf_v;
   assign own_v = own_rd_ok ? own_rd : 8'd0;
   assign suf_v = suf_rd_ok ? suf_rd : 8'd0;

   function automatic logic [7:0] sat8(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[8] ? 8'hFF : s[7:0];
   endfunction

   logic [ScoreBits:0] score_sum;
   assign score_sum = {1'b0, run_ff} + {1'b0, prod_ff[ScoreBits-1:0]};

   assign req_if.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.payload = rsp_ff;

   always_comb begin
      state_in = state_ff;
      total_in = total_ff; cursor_in = cursor_ff; scan_in = scan_ff;
      run_in = run_ff; built_in = built_ff; dropped_in = dropped_ff;
      clr_in = clr_ff; req_in = req_ff; rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      node_in = node_ff; b_in = b_ff; f_in = f_ff; child_in = child_ff;
      head_in = head_ff; tail_in = tail_ff; guard_in = guard_ff;
      root_phase_in = root_phase_ff; matches_in = matches_ff; prod_in = prod_ff;
      cnt_valid_in = cnt_valid_ff;
      goto_we = 1'b0; goto_wa = '0; goto_wd = '0; goto_ra = '0;
      fail_we = 1'b0; fail_wa = '0; fail_wd = '0; fail_ra = '0;
      own_we = 1'b0; own_wa = '0; own_wd = '0; own_ra = '0;
      suf_we = 1'b0; suf_wa = '0; suf_wd = '0; suf_ra = '0;
      q_we = 1'b0; q_wa = '0; q_wd = '0; q_ra = '0;

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            goto_we = 1'b1;
            goto_wa = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == GotoBits'(GotoDepth - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_if.valid && req_if.ready) begin
               req_in = req_if.payload;
               rsp_in = '0;
               rsp_in.score = run_ff;
               unique case (req_if.payload.action)
                  ACT_INSERT: state_in = ST_INS_RD;
                  ACT_SCAN: begin
                     node_in = scan_ff;
                     guard_in = '0;
                     state_in = ST_SC_RD;
                  end
                  ACT_BUILD: begin
                     node_in = '0;
                     b_in = '0;
                     head_in = '0;
                     tail_in = '0;
                     root_phase_in = 1'b1;
                     state_in = ST_BL_RD;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         // ---------------- insert
         ST_INS_RD: begin
            goto_ra = {cursor_ff, req_ff.byte_value};
            state_in = ST_INS_CHK;
         end
         ST_INS_CHK: begin
            if (dropped_ff) begin
               rsp_in.status = 1'b1;
            end else if (goto_rd != '0) begin
               cursor_in = goto_rd;
            end else if (total_ff < CntBits'(MaxNodes)) begin
               goto_we = 1'b1;
               goto_wa = {cursor_ff, req_ff.byte_value};
               goto_wd = total_ff[NodeBits-1:0];
               // a new node fails to the root until the next build
               fail_we = 1'b1;
               fail_wa = total_ff[NodeBits-1:0];
               fail_wd = '0;
               cursor_in = total_ff[NodeBits-1:0];
               total_in = total_ff + 1'b1;
               cnt_valid_in[total_ff[NodeBits-1:0]] = 1'b0;
            end else begin
               rsp_in.status = 1'b1;
               dropped_in = 1'b1;
            end
            own_ra = cursor_in;
            suf_ra = cursor_in;
            state_in = req_ff.last ? ST_INS_END : ST_OUT;
         end
         ST_INS_END: begin
            if (!dropped_ff) begin
               own_we = 1'b1; own_wa = cursor_ff; own_wd = sat8(own_v, 8'd1);
               suf_we = 1'b1; suf_wa = cursor_ff; suf_wd = sat8(suf_v, 8'd1);
               cnt_valid_in[cursor_ff] = 1'b1;
            end
            cursor_in = '0;
            dropped_in = 1'b0;
            state_in = ST_OUT;
         end
         // ---------------- scan
         ST_SC_RD: begin
            goto_ra = {node_ff, req_ff.byte_value};
            fail_ra = node_ff;
            state_in = ST_SC_CHK;
         end
         ST_SC_CHK: begin
            if (node_ff != '0 && goto_rd == '0 && guard_ff < CntBits'(MaxNodes)) begin
               guard_in = guard_ff + 1'b1;
               if (built_ff) begin
                  node_in = fail_rd;
               end else begin
                  node_in = '0;
               end
               state_in = ST_SC_RD;
            end else begin
               if (goto_rd != '0) begin
                  node_in = goto_rd;
               end
               suf_ra = node_in;
               state_in = ST_SC_CNT;
            end
         end
         ST_SC_CNT: begin
            matches_in = suf_v;
            prod_in = 16'(spm_ff * suf_v);
            state_in = ST_SC_MUL;
         end
         ST_SC_MUL: begin
            run_in = score_sum[ScoreBits] ? '1 : score_sum[ScoreBits-1:0];
            rsp_in.position_matches = matches_ff;
            rsp_in.score = run_in;
            scan_in = node_ff;
            if (req_ff.last) begin
               rsp_in.query_done = 1'b1;
               if (run_in <= low_ff) rsp_in.risk_class = RISK_LOW;
               else if (run_in <= med_ff) rsp_in.risk_class = RISK_MEDIUM;
               else if (run_in <= high_ff) rsp_in.risk_class = RISK_HIGH;
               else rsp_in.risk_class = RISK_CRITICAL;
               run_in = '0;
               scan_in = '0;
            end
            state_in = ST_OUT;
         end
         // ---------------- build: node_ff is the parent, b_ff the byte
         ST_BL_RD: begin
            goto_ra = {node_ff, b_ff[7:0]};
            fail_ra = node_ff;
            suf_ra = '0;
            state_in = ST_BL_CHK;
         end
         ST_BL_CHK: begin
            child_in = goto_rd;
            if (root_phase_ff && b_ff == 9'd0) begin
               // root counts settle first
               own_ra = '0;
            end
            if (goto_rd != '0 && tail_ff < CntBits'(MaxNodes)) begin
               own_ra = goto_rd;
               if (root_phase_ff) begin
                  f_in = '0;
                  state_in = ST_BL_CNT;
               end else begin
                  f_in = fail_rd;
                  guard_in = '0;
                  state_in = ST_BL_FRD;
               end
            end else begin
               state_in = ST_BL_Q;
            end
         end
         ST_BL_FRD: begin
            goto_ra = {f_ff, b_ff[7:0]};
            fail_ra = f_ff;
            state_in = ST_BL_FCHK;
         end
         ST_BL_FCHK: begin
            if (f_ff != '0 && goto_rd == '0 && guard_ff < CntBits'(MaxNodes)) begin
               f_in = fail_rd;
               guard_in = guard_ff + 1'b1;
               state_in = ST_BL_FRD;
            end else begin
               f_in = goto_rd;
               own_ra = child_ff;
               suf_ra = goto_rd;
               state_in = ST_BL_CNT;
            end
         end
         ST_BL_CNT: begin
            fail_we = 1'b1; fail_wa = child_ff; fail_wd = f_ff;
            suf_we = 1'b1; suf_wa = child_ff;
            // the root suffix count is zero and the result register holds zero here
            suf_wd = sat8(own_v, root_phase_ff ? rsp_ff.position_matches : suf_v);
            cnt_valid_in[child_ff] = 1'b1;
            own_we = 1'b1; own_wa = child_ff; own_wd = own_v;
            q_we = 1'b1; q_wa = tail_ff[NodeBits-1:0]; q_wd = child_ff;
            tail_in = tail_ff + 1'b1;
            state_in = ST_BL_Q;
         end
         ST_BL_Q: begin
            // advance byte, then next queued parent
            if (b_ff == 9'd255) begin
               if (head_ff < tail_in) begin
                  q_ra = head_ff[NodeBits-1:0];
                  head_in = head_ff + 1'b1;
                  b_in = 9'h1FF;
                  root_phase_in = 1'b0;
                  state_in = ST_BL_Q;
                  node_in = '0;
               end else begin
                  built_in = 1'b1;
                  rsp_in.position_matches = '0;
                  state_in = ST_OUT;
               end
            end else if (b_ff == 9'h1FF) begin
               node_in = q_rd;
               b_in = '0;
               state_in = ST_BL_RD;
            end else begin
               b_in = b_ff + 1'b1;
               state_in = ST_BL_RD;
            end
         end
         ST_OUT: begin
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         spm_ff <= 8'd10; low_ff <= 16'd30; med_ff <= 16'd60; high_ff <= 16'd80;
         total_ff <= CntBits'(1); cursor_ff <= '0; scan_ff <= '0; run_ff <= '0;
         built_ff <= 1'b0; dropped_ff <= 1'b0; clr_ff <= '0;
         rsp_valid_ff <= 1'b0; cnt_valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in; cursor_ff <= cursor_in; scan_ff <= scan_in;
         run_ff <= run_in; built_ff <= built_in; dropped_ff <= dropped_in;
         clr_ff <= clr_in; rsp_valid_ff <= rsp_valid_in; cnt_valid_ff <= cnt_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               REG_SCORE_PER_MATCH: spm_ff <= csr_wdata[7:0];
               REG_LOW_LIMIT:       low_ff <= csr_wdata;
               REG_MEDIUM_LIMIT:    med_ff <= csr_wdata;
               REG_HIGH_LIMIT:      high_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in; node_ff <= node_in; b_ff <= b_in; f_ff <= f_in;
      child_ff <= child_in; head_ff <= head_in; tail_ff <= tail_in;
      guard_ff <= guard_in; root_phase_ff <= root_phase_in;
      matches_ff <= matches_in; prod_ff <= prod_in;
      own_rd_ok <= cnt_valid_in[own_ra] | cnt_valid_ff[own_ra];
      suf_rd_ok <= cnt_valid_ff[suf_ra];
      rsp_ff <= rsp_in;
   end

   `MPMS_ASSERT_ALWAYS(a_rst_idle, clock, reset |=> !rsp_valid_ff,
      "result valid right after reset")
   `MPMS_ASSERT(a_ready_idle, clock, reset, req_if.ready |-> !rsp_valid_ff,
      "ready while result pending")
   `MPMS_ASSERT(a_total, clock, reset, total_ff <= CntBits'(MaxNodes) && total_ff != '0,
      "node total out of range")
endmodule
